>>> hw/rtl/i2a_pkg.sv
// shared types and constants for the integer to ascii converter
package i2a_pkg;

    // item field widths
    localparam int VALUE_W     = 32;
    localparam int BASE_W      = 5;
    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = 4;

    // digit store sizing
    localparam int MAX_DIGITS  = 32;
    localparam int ADDR_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);

    // divider: quotient bits resolved per cycle
    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = VALUE_W / DIV_BITS;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // valid radix range
    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

    // ascii codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;

    // one classified conversion job
    typedef struct packed {
        logic                err;
        logic [BASE_W-1:0]   base;
        logic [VALUE_W-1:0]  value;
    } job_t;

endpackage

>>> hw/rtl/i2a_front.sv
// front end: input register and radix range check
module i2a_front
    import i2a_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] in_value,
    input  logic [BASE_W-1:0]  in_base,
    output logic               push_valid,
    input  logic               push_ready,
    output job_t               push_job
);

    logic valid_reg;
    logic valid_next;
    job_t job_reg;
    job_t job_next;
    logic in_take;

    // stage frees up when empty or when its job moves into the queue
    assign in_ready = !valid_reg || push_ready;
    assign in_take  = in_valid && in_ready;

    // classify the incoming item
    always_comb begin
        job_next = job_reg;
        valid_next = valid_reg;
        if (push_ready) begin
            valid_next = 1'b0;
        end
        if (in_take) begin
            valid_next     = 1'b1;
            job_next.value = in_value;
            job_next.base  = in_base;
            job_next.err   = (in_base < BASE_MIN) || (in_base > BASE_MAX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        job_reg <= job_next;
    end

    assign push_valid = valid_reg;
    assign push_job   = job_reg;

endmodule

>>> hw/rtl/i2a_queue.sv
// short job queue between front and back
module i2a_queue
    import i2a_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> hw/rtl/i2a_back.sv
// back end: iterative divider, digit store and character output register
module i2a_back
    import i2a_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  job_t              pop_job,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last,
    output logic              out_err
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_OUT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [VALUE_W-1:0]  quot_reg;
    logic [VALUE_W-1:0]  quot_next;
    logic [DIGIT_W-1:0]  rem_reg;
    logic [DIGIT_W-1:0]  rem_next;
    logic [BASE_W-1:0]   base_reg;
    logic [BASE_W-1:0]   base_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                ov_reg;
    logic                ov_next;
    logic [CHAR_W-1:0]   char_reg;
    logic [CHAR_W-1:0]   char_next;
    logic                last_reg;
    logic                last_next;
    logic                err_reg;
    logic                err_next;

    logic [DIGIT_W-1:0]  digit_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0]  rd_data_reg;
    logic                wr_en;
    logic [CNT_W-1:0]    rd_idx;
    logic [CNT_W-1:0]    cnt_inc;
    logic                out_free;
    logic                take_job;

    logic [BASE_W-1:0]   part_rem;
    logic [DIV_BITS-1:0] part_quot;

    // digit value to ascii
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10)) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
        end
        return c;
    endfunction

    assign out_free = !ov_reg || out_ready;
    assign rd_idx   = cnt_reg - 1'b1;
    assign cnt_inc  = cnt_reg + 1'b1;

    // a bad radix needs the output register, a good one only the divider
    assign pop_ready = (state_reg == ST_IDLE) && (!pop_job.err || out_free);
    assign take_job  = pop_valid && pop_ready;

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb begin
        part_rem  = {1'b0, rem_reg};
        part_quot = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            part_rem = {part_rem[DIGIT_W-1:0], quot_reg[VALUE_W-1-i]};
            if (part_rem >= base_reg) begin
                part_rem     = part_rem - base_reg;
                part_quot[DIV_BITS-1-i] = 1'b1;
            end
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        base_next  = base_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        ov_next    = ov_reg && !out_ready;
        wr_en      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (take_job) begin
                    if (pop_job.err) begin
                        ov_next   = 1'b1;
                        char_next = CHAR_ZERO;
                        last_next = 1'b1;
                        err_next  = 1'b1;
                    end else begin
                        quot_next  = pop_job.value;
                        base_next  = pop_job.base;
                        rem_next   = '0;
                        step_next  = '0;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                quot_next = {quot_reg[VALUE_W-DIV_BITS-1:0], part_quot};
                rem_next  = part_rem[DIGIT_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    // one digit done: store remainder, go on with quotient
                    wr_en    = 1'b1;
                    cnt_next = cnt_inc;
                    rem_next = '0;
                    if (quot_next == '0 || cnt_inc == CNT_W'(MAX_DIGITS)) begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    ov_next   = 1'b1;
                    char_next = digit_char(rd_data_reg);
                    last_next = (rd_idx == '0);
                    err_next  = 1'b0;
                    cnt_next  = rd_idx;
                    if (rd_idx == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
            quot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
            quot_reg  <= quot_next;
        end
        rem_reg  <= rem_next;
        base_reg <= base_next;
        step_reg <= step_next;
        char_reg <= char_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    // digit store, least significant digit at address zero
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            digit_mem[cnt_reg[ADDR_W-1:0]] <= part_rem[DIGIT_W-1:0];
        end
        rd_data_reg <= digit_mem[rd_idx[ADDR_W-1:0]];
    end

    assign out_valid = ov_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign out_err   = err_reg;

endmodule

>>> hw/rtl/integer_to_ascii_any_base.sv
// top level: unsigned integer to ascii text in radix 2 to 16
//
// s_axis takes one item per number: tdata[31:0] is the value, tdata[36:32]
// the radix. m_axis gives one item per character, most significant digit
// first, '0'-'9' then 'A'-'F' in tdata[6:0]; tlast marks the final
// character, tuser flags a radix outside 2..16 (one '0' item, tlast set).
// A zero value gives a single '0'.
// The front registers and checks each item and drops it into a two-entry
// queue, so up to three items can be taken while the back is busy.
// The back divides by the radix eight quotient bits per cycle, one digit per
// pass over the quotient, then reads each character back from the digit store.
// The first character comes out only once every digit has been divided out.
// When the receiver stalls, the output register holds its character and
// the back waits; the front accepts until queue and input register are full.
// Reset (aresetn low, synchronous) empties the queue and the output
// register; no clearing pass is needed.
module integer_to_ascii_any_base
    import i2a_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], base[36:32], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // character[6:0], zero fill
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // error[0]
);

    logic              push_valid;
    logic              push_ready;
    job_t              push_job;
    logic              pop_valid;
    logic              pop_ready;
    job_t              pop_job;
    logic [CHAR_W-1:0] out_char;

    i2a_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_value   (s_axis_tdata[VALUE_W-1:0]),
        .in_base    (s_axis_tdata[VALUE_W+BASE_W-1:VALUE_W]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    i2a_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    i2a_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (out_char),
        .out_last  (m_axis_tlast),
        .out_err   (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

>>> tb/testbench.sv
// self-checking testbench for the radix 2..16 integer to ascii converter
module testbench;
    import i2a_pkg::*;

    localparam int RUN_LIMIT    = 3_000_000;
    localparam int RANDOM_ITEMS = 145;
    localparam int SETTLE       = 300;

    // one expected output character
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              err;
    } glyph_t;

    // one row of the directed plan; empty text means the predictor decides
    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [BASE_W-1:0]  base;
        string              text;
        logic               err;
    } plan_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;     // value[31:0], base[36:32], zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // character[6:0], zero fill
    logic        m_axis_tlast;
    logic        m_axis_tuser;           // error[0]

    glyph_t chars_due[$];
    int     fail_count = 0;

    // directed plan: extremes, every radix, zero value, out of range radix
    plan_row_t plan[25] = '{
        '{32'd0,         5'd10, "0", 1'b0},
        '{32'd0,         5'd2,  "0", 1'b0},
        '{32'hFFFF_FFFF, 5'd2,  "11111111111111111111111111111111", 1'b0},
        '{32'hFFFF_FFFF, 5'd16, "FFFFFFFF", 1'b0},
        '{32'hFFFF_FFFF, 5'd10, "4294967295", 1'b0},
        '{32'hFFFF_FFFF, 5'd8,  "37777777777", 1'b0},
        '{32'd1,         5'd16, "1", 1'b0},
        '{32'd15,        5'd16, "F", 1'b0},
        '{32'd16,        5'd16, "10", 1'b0},
        '{32'h89AB_CDEF, 5'd16, "89ABCDEF", 1'b0},
        '{32'hFFFF_FFFF, 5'd0,  "0", 1'b1},
        '{32'd0,         5'd1,  "0", 1'b1},
        '{32'd5,         5'd17, "0", 1'b1},
        '{32'hFFFF_FFFF, 5'd31, "0", 1'b1},
        '{32'd12345,     5'd3,  "", 1'b0},
        '{32'h8000_0000, 5'd4,  "", 1'b0},
        '{32'd999_999,   5'd5,  "", 1'b0},
        '{32'h7FFF_FFFF, 5'd6,  "", 1'b0},
        '{32'h1234_5678, 5'd7,  "", 1'b0},
        '{32'd80,        5'd9,  "", 1'b0},
        '{32'hDEAD_BEEF, 5'd11, "", 1'b0},
        '{32'd143,       5'd12, "", 1'b0},
        '{32'd168,       5'd13, "", 1'b0},
        '{32'hFFFF_FFFE, 5'd14, "", 1'b0},
        '{32'd224,       5'd15, "", 1'b0}
    };

    integer_to_ascii_any_base dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 10) return 0;
        if (roll < 18) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // expected characters of one number, most significant digit first
    function automatic void predict_text(input logic [VALUE_W-1:0] value,
                                         input logic [BASE_W-1:0] base);
        logic [DIGIT_W-1:0] digits[MAX_DIGITS];
        logic [VALUE_W-1:0] quotient;
        logic [CHAR_W-1:0]  glyph;
        int                 count;
        if (base < BASE_MIN || base > BASE_MAX) begin
            chars_due.push_back(glyph_t'{CHAR_ZERO, 1'b1, 1'b1});
            return;
        end
        quotient = value;
        count = 0;
        do begin
            digits[count] = DIGIT_W'(quotient % VALUE_W'(base));
            quotient = quotient / VALUE_W'(base);
            count++;
        end while (quotient != 0 && count < MAX_DIGITS);
        for (int i = count - 1; i >= 0; i--) begin
            glyph = (digits[i] < 10) ? CHAR_ZERO + CHAR_W'(digits[i])
                                     : CHAR_A + CHAR_W'(digits[i]) - CHAR_W'(10);
            chars_due.push_back(glyph_t'{glyph, (i == 0), 1'b0});
        end
    endfunction

    // offer one number, wait for the handshake, then record what must come out
    task automatic send_number(input logic [VALUE_W-1:0] value,
                               input logic [BASE_W-1:0] base,
                               input string text, input logic err, input bit steady);
        int idle;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, base, value};
        do @(posedge aclk); while (s_axis_tready !== 1'b1);
        if (text.len() == 0) begin
            predict_text(value, base);
        end else begin
            for (int i = 0; i < text.len(); i++)
                chars_due.push_back(glyph_t'{CHAR_W'(text[i]), (i == text.len() - 1), err});
        end
        idle = steady ? 0 : pick_idle();
        if (idle > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
    endtask

    // receiver: ready runs and stalls of random length
    initial begin : result_sink
        int run_left;
        bit ready_now;
        run_left  = 0;
        ready_now = 1'b0;
        forever begin
            @(posedge aclk);
            if (run_left > 0) begin
                run_left--;
            end else begin
                ready_now = !ready_now;
                if (ready_now)
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(0, 12);
                else
                    run_left = pick_idle();
            end
            m_axis_tready <= ready_now;
        end
    end

    // compare every accepted output item with the oldest expected character
    always @(posedge aclk) begin
        glyph_t want;
        if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (chars_due.size() == 0) begin
                $error("unexpected item: character %h last %b error %b",
                       m_axis_tdata[CHAR_W-1:0], m_axis_tlast, m_axis_tuser);
                fail_count++;
            end else begin
                want = chars_due.pop_front();
                if (m_axis_tdata[CHAR_W-1:0] !== want.character) begin
                    $error("character: expected %h, got %h",
                           want.character, m_axis_tdata[CHAR_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tuser !== want.err) begin
                    $error("error: expected %b, got %b", want.err, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        logic [VALUE_W-1:0] value;
        logic [BASE_W-1:0]  base;
        logic [VALUE_W-1:0] power;
        int                 shape;
        int                 steps;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed plan
        foreach (plan[i])
            send_number(plan[i].value, plan[i].base, plan[i].text, plan[i].err, 1'b0);

        // random numbers, mostly valid radix
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 9) == 0)
                base = $urandom_range(0, 1) ? BASE_W'($urandom_range(0, 1))
                                            : BASE_W'($urandom_range(17, 31));
            else
                base = BASE_W'($urandom_range(2, 16));
            shape = $urandom_range(0, 3);
            case (shape)
                0: value = $urandom;
                1: value = $urandom_range(0, 255);
                2: value = $urandom >> $urandom_range(0, 31);
                default: begin
                    // near a power of the radix, where the digit count changes
                    power = 1;
                    steps = $urandom_range(1, 31);
                    while (steps > 0 && base >= BASE_MIN && base <= BASE_MAX
                           && power <= 32'hFFFF_FFFF / VALUE_W'(base)) begin
                        power = power * VALUE_W'(base);
                        steps--;
                    end
                    value = power + VALUE_W'($urandom_range(0, 2)) - 1;
                end
            endcase

            // hold off once until every expected character has come out
            if (n == RANDOM_ITEMS / 2) begin
                s_axis_tvalid <= 1'b0;
                while (chars_due.size() != 0) @(posedge aclk);
            end
            send_number(value, base, "", 1'b0, (n >= 120 && n < 140));
        end
        s_axis_tvalid <= 1'b0;

        // drain and let the block settle
        while (chars_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_front.sv
hw/rtl/i2a_queue.sv
hw/rtl/i2a_back.sv
hw/rtl/integer_to_ascii_any_base.sv
tb/testbench.sv
